// File: hw/rtl/pdsc_pkg.sv
`default_nettype none
package pdsc_pkg;

   localparam int DataBytesDefault = 32;
   localparam int HeaderBytes      = 6;

   localparam int PosW   = 11;
   localparam int IndexW = 10;
   localparam int SumW   = 16;

   // Fixed positions of the header within a frame
   localparam logic [PosW-1:0] PosChecksumLo = PosW'(0);
   localparam logic [PosW-1:0] PosChecksumHi = PosW'(1);
   localparam logic [PosW-1:0] PosStatus     = PosW'(2);
   localparam logic [PosW-1:0] PosAddress    = PosW'(3);
   localparam logic [PosW-1:0] PosNumber     = PosW'(4);
   localparam logic [PosW-1:0] PosTotal      = PosW'(5);
   localparam logic [PosW-1:0] PosFirstData  = PosW'(HeaderBytes);

   typedef struct packed {
      logic       restart;
      logic [7:0] rx_byte;
   } pdsc_req_type;

   typedef struct packed {
      logic [7:0]        frame_total;
      logic [7:0]        frame_number;
      logic [7:0]        frame_address;
      logic [7:0]        frame_status;
      logic [SumW-1:0]   frame_checksum;
      logic              checksum_ok;
      logic              frame_done;
      logic [7:0]        data_byte;
      logic [IndexW-1:0] data_index;
      logic              data_valid;
   } pdsc_rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/pdsc_in_stage.sv
`default_nettype none
module pdsc_in_stage
   import pdsc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output      logic         in_ready,
   input  wire pdsc_req_type in_word,
   output      logic         held_valid,
   input  wire logic         advance,
   output      pdsc_req_type held_word
);

   logic         valid_ff;
   logic         valid_in;
   pdsc_req_type word_ff;

   // Take a new word when empty or when the held one moves on this cycle
   assign in_ready = !valid_ff || advance;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= in_word;
      end
   end

   assign held_valid = valid_ff;
   assign held_word  = word_ff;

endmodule
`default_nettype wire

// File: hw/rtl/pdsc_core.sv
`default_nettype none
module pdsc_core
   import pdsc_pkg::*;
#(
   parameter int DATA_BYTES = DataBytesDefault
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire pdsc_req_type req,
   output      pdsc_rsp_type rsp
);

   localparam int FrameBytes = DATA_BYTES + HeaderBytes;
   localparam logic [PosW-1:0] FrameLen  = PosW'(FrameBytes);
   localparam logic [PosW-1:0] FrameLast = PosW'(FrameBytes - 1);

   logic [PosW-1:0] pos_ff, pos_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic [SumW-1:0] csum_ff, csum_in;
   logic [7:0]      status_ff, status_in;
   logic [7:0]      address_ff, address_in;
   logic [7:0]      number_ff, number_in;
   logic [7:0]      total_ff, total_in;

   logic [PosW-1:0] pos;
   logic [PosW-1:0] data_off;
   logic            done;

   always_comb begin
      pos = req.restart ? PosChecksumLo : pos_ff;
      if (pos >= FrameLen) begin
         pos = PosChecksumLo;
      end

      sum_in     = sum_ff;
      csum_in    = csum_ff;
      status_in  = status_ff;
      address_in = address_ff;
      number_in  = number_ff;
      total_in   = total_ff;

      // Clear the sum at frame start, then add every byte after the checksum
      priority if (pos == PosChecksumLo) begin
         sum_in  = '0;
         csum_in = {csum_ff[15:8], req.rx_byte};
      end else if (pos == PosChecksumHi) begin
         csum_in = {req.rx_byte, csum_ff[7:0]};
      end else begin
         sum_in = sum_ff + SumW'(req.rx_byte);
         if (pos == PosStatus) begin
            status_in = req.rx_byte;
         end else if (pos == PosAddress) begin
            address_in = req.rx_byte;
         end else if (pos == PosNumber) begin
            number_in = req.rx_byte;
         end else if (pos == PosTotal) begin
            total_in = req.rx_byte;
         end
      end

      done     = (pos == FrameLast);
      pos_in   = done ? PosChecksumLo : pos + PosW'(1);
      data_off = pos - PosFirstData;

      rsp.data_valid     = (pos >= PosFirstData);
      rsp.data_index     = rsp.data_valid ? data_off[IndexW-1:0] : '0;
      rsp.data_byte      = req.rx_byte;
      rsp.frame_done     = done;
      rsp.checksum_ok    = done && (sum_in == csum_in);
      rsp.frame_checksum = done ? csum_in : '0;
      rsp.frame_status   = done ? status_in : '0;
      rsp.frame_address  = done ? address_in : '0;
      rsp.frame_number   = done ? number_in : '0;
      rsp.frame_total    = done ? total_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         sum_ff     <= '0;
         csum_ff    <= '0;
         status_ff  <= '0;
         address_ff <= '0;
         number_ff  <= '0;
         total_ff   <= '0;
      end else if (advance) begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         csum_ff    <= csum_in;
         status_ff  <= status_in;
         address_ff <= address_in;
         number_ff  <= number_in;
         total_ff   <= total_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/pdsc_out_stage.sv
`default_nettype none
module pdsc_out_stage
   import pdsc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         held_valid,
   output      logic         advance,
   input  wire pdsc_rsp_type rsp_next,
   output      logic         out_valid,
   input  wire logic         out_ready,
   output      pdsc_rsp_type out_word
);

   logic         valid_ff;
   logic         valid_in;
   pdsc_rsp_type word_ff;

   // Advance when a word is held and the result slot is free or draining
   assign advance  = held_valid && (!valid_ff || out_ready);
   assign valid_in = advance ? 1'b1 : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= rsp_next;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

// File: hw/rtl/packet_deframer_sum_check_top.sv
// A word accepted into the input register is loaded into the result register
// when the result slot is free.
// Throughput: one byte per cycle while the result slot is free; the position
// counter and 16-bit sum update combinationally between input and result registers.
// Reset (synchronous, active high) empties both registers and clears the
// byte position, running sum and held header fields.
`default_nettype none
module packet_deframer_sum_check_top
   import pdsc_pkg::*;
#(
   parameter int DATA_BYTES = DataBytesDefault
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // restart
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [71:0] rsp_tdata,   // [9:0] data_index, [17:10] data_byte,
                                         // [33:18] frame_checksum, [41:34] frame_status,
                                         // [49:42] frame_address, [57:50] frame_number,
                                         // [65:58] frame_total, [71:66] zero
   output      logic        rsp_tlast,   // frame_done
   output      logic [1:0]  rsp_tuser    // [0] data_valid, [1] checksum_ok
);

   pdsc_req_type in_word;
   pdsc_req_type held_word;
   pdsc_rsp_type rsp_next;
   pdsc_rsp_type out_word;
   logic         held_valid;
   logic         advance;

   assign in_word.rx_byte = req_tdata;
   assign in_word.restart = req_tuser;

   pdsc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_word    (in_word),
      .held_valid (held_valid),
      .advance    (advance),
      .held_word  (held_word)
   );

   pdsc_core #(
      .DATA_BYTES (DATA_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (held_word),
      .rsp     (rsp_next)
   );

   pdsc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .held_valid (held_valid),
      .advance    (advance),
      .rsp_next   (rsp_next),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (out_word)
   );

   assign rsp_tdata = {6'b0,
                       out_word.frame_total,
                       out_word.frame_number,
                       out_word.frame_address,
                       out_word.frame_status,
                       out_word.frame_checksum,
                       out_word.data_byte,
                       out_word.data_index};
   assign rsp_tlast = out_word.frame_done;
   assign rsp_tuser = {out_word.checksum_ok, out_word.data_valid};

endmodule
`default_nettype wire
